FILE: rtl/u8sd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ---------------------------------------------------------------------------
package u8sd_pkg;

   localparam int ByteWidth  = 8;
   localparam int CpWidth    = 21;
   localparam int RspDepth   = 4;
   localparam int RspPtrBits = $clog2(RspDepth);
   localparam int RspCntBits = $clog2(RspDepth + 1);

   localparam logic [CpWidth-1:0]   ReplacementChar = 21'h00FFFD;
   localparam logic [ByteWidth-1:0] ContTestMask    = 8'hC0;
   localparam logic [ByteWidth-1:0] ContTag         = 8'h80;
   localparam logic [ByteWidth-1:0] ContPayload     = 8'h3F;
   localparam logic [ByteWidth-1:0] LeadTwoMin      = 8'hC0;
   localparam logic [ByteWidth-1:0] LeadThreeMin    = 8'hE0;
   localparam logic [ByteWidth-1:0] LeadFourMin     = 8'hF0;
   localparam logic [ByteWidth-1:0] LeadMax         = 8'hF4;
   localparam logic [ByteWidth-1:0] LeadMaskTwo     = 8'h1F;
   localparam logic [ByteWidth-1:0] LeadMaskThree   = 8'h0F;
   localparam logic [ByteWidth-1:0] LeadMaskFour    = 8'h07;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               bad_sequence;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         pending;
      logic [CpWidth-1:0] partial;
      logic [1:0]         rsp_count;
      rsp_type            rsp0;
      rsp_type            rsp1;
   } dec_type;

endpackage

FILE: rtl/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder, one byte per request.
//
//   channel  direction  payload                                   handshake
//   req      in         req_in_byte                               req_valid/req_ready
//   rsp      out        rsp_code_point, rsp_bad_sequence,         rsp_valid/rsp_ready
//                       rsp_last_of_run
//
// One request per cycle sustained while the queue has room; a request passes
// through the input register, then the response queue, before its first
// response can leave.
// A zero byte that breaks an open sequence yields two responses, which
// leave the queue in order, the replacement first.
// Reset clears the open sequence, the input register and the queue.
// A stalled rsp side holds the input register once the queue has fewer
// than two free slots; req_ready then drops.
// ---------------------------------------------------------------------------
module utf8_stream_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [u8sd_pkg::ByteWidth-1:0] req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [u8sd_pkg::CpWidth-1:0]  rsp_code_point,
   output logic                          rsp_bad_sequence,
   output logic                          rsp_last_of_run
);

   logic                          in_valid_ff, in_valid_in;
   logic [u8sd_pkg::ByteWidth-1:0] in_byte_ff;
   logic [1:0]                    pending_ff;
   logic [u8sd_pkg::CpWidth-1:0]  partial_ff;
   logic                          room;
   logic                          advance;
   logic                          req_fire;
   logic [1:0]                    push_count;
   u8sd_pkg::dec_type             dec;
   u8sd_pkg::rsp_type             rsp_data;

   assign advance    = in_valid_ff && room;
   assign req_ready  = !in_valid_ff || room;
   assign req_fire   = req_valid && req_ready;
   assign push_count = advance ? dec.rsp_count : 2'd0;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pending_ff  <= 2'd0;
         partial_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            pending_ff <= dec.pending;
            partial_ff <= dec.partial;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_in_byte;
      end
   end

   u8sd_decode u_decode (
      .in_byte (in_byte_ff),
      .pending (pending_ff),
      .partial (partial_ff),
      .dec     (dec)
   );

   u8sd_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (dec.rsp0),
      .push1      (dec.rsp1),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_code_point   = rsp_data.code_point;
   assign rsp_bad_sequence = rsp_data.bad_sequence;
   assign rsp_last_of_run  = rsp_data.last_of_run;

   assert property (@(posedge clock) disable iff (reset)
      ((pending_ff == 2'd0) && (partial_ff == '0)) ||
      ((pending_ff == 2'd1) && (partial_ff[u8sd_pkg::CpWidth-1:15] == '0)) ||
      ((pending_ff == 2'd2) && (partial_ff[u8sd_pkg::CpWidth-1:9] == '0)) ||
      ((pending_ff == 2'd3) && (partial_ff[u8sd_pkg::CpWidth-1:3] == '0)))
      else $error("partial value wider than open sequence allows");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run) |=> rsp_valid)
      else $error("second response of a request missing");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> rsp_bad_sequence)
      else $error("non-final response must be a replacement");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !room) |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register lost a held request");

endmodule

FILE: rtl/u8sd_decode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u8sd_decode
// Single-pass decode of one byte against the open sequence state: gives the
// next state and zero, one or two responses.
// ---------------------------------------------------------------------------
module u8sd_decode (
   input  logic [u8sd_pkg::ByteWidth-1:0] in_byte,
   input  logic [1:0]                     pending,
   input  logic [u8sd_pkg::CpWidth-1:0]   partial,
   output u8sd_pkg::dec_type              dec
);

   logic [u8sd_pkg::CpWidth-1:0] shifted;
   logic [1:0]                   pending_dec;

   assign shifted     = {partial[u8sd_pkg::CpWidth-7:0],
                         in_byte[5:0] & u8sd_pkg::ContPayload[5:0]};
   assign pending_dec = pending - 2'd1;

   always_comb begin
      dec.pending   = pending;
      dec.partial   = partial;
      dec.rsp_count = 2'd0;
      dec.rsp0      = '{code_point: u8sd_pkg::ReplacementChar, bad_sequence: 1'b1,
                        last_of_run: 1'b1};
      dec.rsp1      = '{code_point: '0, bad_sequence: 1'b0, last_of_run: 1'b1};
      if (pending == 2'd0) begin
         if (!in_byte[7]) begin
            dec.rsp_count       = 2'd1;
            dec.rsp0.code_point = {{(u8sd_pkg::CpWidth-u8sd_pkg::ByteWidth){1'b0}}, in_byte};
            dec.rsp0.bad_sequence = 1'b0;
         end else if (in_byte < u8sd_pkg::LeadTwoMin || in_byte > u8sd_pkg::LeadMax) begin
            dec.rsp_count = 2'd1;
         end else if (in_byte < u8sd_pkg::LeadThreeMin) begin
            dec.pending = 2'd1;
            dec.partial = {{(u8sd_pkg::CpWidth-u8sd_pkg::ByteWidth){1'b0}},
                           in_byte & u8sd_pkg::LeadMaskTwo};
         end else if (in_byte < u8sd_pkg::LeadFourMin) begin
            dec.pending = 2'd2;
            dec.partial = {{(u8sd_pkg::CpWidth-u8sd_pkg::ByteWidth){1'b0}},
                           in_byte & u8sd_pkg::LeadMaskThree};
         end else begin
            dec.pending = 2'd3;
            dec.partial = {{(u8sd_pkg::CpWidth-u8sd_pkg::ByteWidth){1'b0}},
                           in_byte & u8sd_pkg::LeadMaskFour};
         end
      end else if ((in_byte & u8sd_pkg::ContTestMask) != u8sd_pkg::ContTag) begin
         dec.pending = 2'd0;
         dec.partial = '0;
         if (in_byte == '0) begin
            dec.rsp_count        = 2'd2;
            dec.rsp0.last_of_run = 1'b0;
         end else begin
            dec.rsp_count = 2'd1;
         end
      end else begin
         dec.pending = pending_dec;
         if (pending_dec == 2'd0) begin
            dec.partial           = '0;
            dec.rsp_count         = 2'd1;
            dec.rsp0.code_point   = shifted;
            dec.rsp0.bad_sequence = 1'b0;
         end else begin
            dec.partial = shifted;
         end
      end
   end

endmodule

FILE: rtl/u8sd_rsp_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// u8sd_rsp_queue
// Small response queue: takes up to two responses per cycle, hands out one.
// ---------------------------------------------------------------------------
module u8sd_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_count,
   input  u8sd_pkg::rsp_type    push0,
   input  u8sd_pkg::rsp_type    push1,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output u8sd_pkg::rsp_type    rsp_data
);

   u8sd_pkg::rsp_type                entry_ff [u8sd_pkg::RspDepth];
   logic [u8sd_pkg::RspPtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [u8sd_pkg::RspPtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [u8sd_pkg::RspCntBits-1:0]  count_ff, count_in;
   logic [u8sd_pkg::RspPtrBits-1:0]  wr_next;
   logic                             pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign room      = (count_ff <= u8sd_pkg::RspCntBits'(u8sd_pkg::RspDepth - 2));
   assign wr_next   = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + u8sd_pkg::RspPtrBits'(push_count);
      rd_ptr_in = rd_ptr_ff + u8sd_pkg::RspPtrBits'(pop);
      count_in  = count_ff + u8sd_pkg::RspCntBits'(push_count)
                  - u8sd_pkg::RspCntBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_next] <= push1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= u8sd_pkg::RspCntBits'(u8sd_pkg::RspDepth))
      else $error("response queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      (push_count != 2'd0) |-> room)
      else $error("push into full response queue");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("held response changed");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 stream decoder. A queue of request
// bytes (directed edge cases, then mostly well-formed multi-byte sequences
// mixed with broken sequences and raw noise) feeds a clocked driver. Each
// accepted byte runs through a local decoder model that queues the expected
// code points. A clocked monitor compares every response, field by field,
// against the oldest expected code point. Both sides idle at random, and
// the response side holds off once for a long stretch to back up the block.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int ItemCount  = 1200;
   localparam int CycleLimit = 100000;
   localparam int CalmFirst  = 400;
   localparam int CalmLast   = 750;
   localparam int HoldStart  = 150;
   localparam int HoldCycles = 80;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [u8sd_pkg::ByteWidth-1:0] req_in_byte = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [u8sd_pkg::CpWidth-1:0]   rsp_code_point;
   logic                           rsp_bad_sequence;
   logic                           rsp_last_of_run;

   logic [u8sd_pkg::ByteWidth-1:0] pending_bytes[$];
   u8sd_pkg::rsp_type              expected_chars[$];
   u8sd_pkg::rsp_type              want;

   logic [1:0]                     seq_left  = '0;
   logic [u8sd_pkg::CpWidth-1:0]   seq_value = '0;

   int unsigned          accepted_count = 0;
   int unsigned          fail_count = 0;
   int unsigned          cycle_count = 0;
   int unsigned          hold_left = 0;
   bit                   hold_done = 1'b0;

   utf8_stream_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_point   (rsp_code_point),
      .rsp_bad_sequence (rsp_bad_sequence),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always #4 clock = ~clock;

   task automatic push_char(input logic [u8sd_pkg::CpWidth-1:0] cp, input logic bad,
                            input logic last);
      u8sd_pkg::rsp_type r;
      r.code_point   = cp;
      r.bad_sequence = bad;
      r.last_of_run  = last;
      expected_chars.push_back(r);
   endtask

   task automatic decode_byte(input logic [u8sd_pkg::ByteWidth-1:0] b);
      if (seq_left == 2'd0) begin
         if (b < u8sd_pkg::ContTag) begin
            push_char(u8sd_pkg::CpWidth'(b), 1'b0, 1'b1);
         end else if (b < u8sd_pkg::LeadTwoMin || b > u8sd_pkg::LeadMax) begin
            push_char(u8sd_pkg::ReplacementChar, 1'b1, 1'b1);
         end else if (b < u8sd_pkg::LeadThreeMin) begin
            seq_left  = 2'd1;
            seq_value = u8sd_pkg::CpWidth'(b & u8sd_pkg::LeadMaskTwo);
         end else if (b < u8sd_pkg::LeadFourMin) begin
            seq_left  = 2'd2;
            seq_value = u8sd_pkg::CpWidth'(b & u8sd_pkg::LeadMaskThree);
         end else begin
            seq_left  = 2'd3;
            seq_value = u8sd_pkg::CpWidth'(b & u8sd_pkg::LeadMaskFour);
         end
      end else if ((b & u8sd_pkg::ContTestMask) != u8sd_pkg::ContTag) begin
         seq_left  = 2'd0;
         seq_value = '0;
         if (b == 8'h00) begin
            push_char(u8sd_pkg::ReplacementChar, 1'b1, 1'b0);
            push_char('0, 1'b0, 1'b1);
         end else begin
            push_char(u8sd_pkg::ReplacementChar, 1'b1, 1'b1);
         end
      end else begin
         seq_value = (seq_value << 6) + u8sd_pkg::CpWidth'(b & u8sd_pkg::ContPayload);
         seq_left  = seq_left - 2'd1;
         if (seq_left == 2'd0) begin
            push_char(seq_value, 1'b0, 1'b1);
            seq_value = '0;
         end
      end
   endtask

   function automatic bit take_break();
      if (accepted_count >= CalmFirst && accepted_count < CalmLast) return 1'b0;
      return $urandom_range(99) < 30;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_in_byte);
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() > 0 && !take_break()) begin
               req_valid   <= 1'b1;
               req_in_byte <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected response: code_point %h", rsp_code_point);
               fail_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_code_point !== want.code_point) begin
                  $error("code_point expected %h actual %h", want.code_point, rsp_code_point);
                  fail_count++;
               end
               if (rsp_bad_sequence !== want.bad_sequence) begin
                  $error("bad_sequence expected %b actual %b",
                         want.bad_sequence, rsp_bad_sequence);
                  fail_count++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $error("last_of_run expected %b actual %b",
                         want.last_of_run, rsp_last_of_run);
                  fail_count++;
               end
            end
         end
         // hold off once to back up the block
         if (!hold_done && accepted_count >= HoldStart) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !take_break();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [u8sd_pkg::ByteWidth-1:0] directed[];
      logic [u8sd_pkg::ByteWidth-1:0] lo, hi, b;
      int unsigned kind, len, conts;

      directed = '{
         8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF5, 8'hF6, 8'hFF,
         8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
         8'hE2, 8'h41, 8'hC3, 8'h00, 8'hE0, 8'hC3, 8'hF0, 8'hFF, 8'hDF, 8'hBF
      };

      foreach (directed[i]) pending_bytes.push_back(directed[i]);

      while (pending_bytes.size() < ItemCount + directed.size()) begin
         kind = $urandom_range(99);
         if (kind < 80) begin
            len = (kind < 55) ? $urandom_range(1, 4) : $urandom_range(2, 4);
            case (len)
               1: begin lo = 8'h00;                  hi = 8'h7F;             end
               2: begin lo = u8sd_pkg::LeadTwoMin;   hi = 8'hDF;             end
               3: begin lo = u8sd_pkg::LeadThreeMin; hi = 8'hEF;             end
               default: begin lo = u8sd_pkg::LeadFourMin; hi = u8sd_pkg::LeadMax; end
            endcase
            pending_bytes.push_back(u8sd_pkg::ByteWidth'($urandom_range(lo, hi)));
            // well-formed: all continuations; broken: short, then an interrupter
            conts = (kind < 55) ? len - 1 : $urandom_range(0, len - 2);
            repeat (conts) begin
               pending_bytes.push_back(u8sd_pkg::ContTag |
                                       u8sd_pkg::ByteWidth'($urandom_range(0, 63)));
            end
            if (kind >= 55) begin
               if ($urandom_range(3) == 0) begin
                  b = 8'h00;
               end else begin
                  do b = u8sd_pkg::ByteWidth'($urandom_range(0, 255));
                  while ((b & u8sd_pkg::ContTestMask) == u8sd_pkg::ContTag);
               end
               pending_bytes.push_back(b);
            end
         end else begin
            pending_bytes.push_back(u8sd_pkg::ByteWidth'($urandom_range(0, 255)));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() > 0 || req_valid) @(posedge clock);
      while (expected_chars.size() > 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: utf8_stream_decoder.f
rtl/u8sd_pkg.sv
rtl/u8sd_decode.sv
rtl/u8sd_rsp_queue.sv
rtl/utf8_stream_decoder.sv
tb/tb_top.sv
